>>> hdl/soc_pkg.sv
`default_nettype none

package soc_pkg;

	localparam int MAX_PATTERN_DEF = 64;

	localparam logic REQ_PATTERN = 1'b0;
	localparam logic REQ_TEXT    = 1'b1;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic               req_type;
		logic signed [31:0] element_value;
		logic               last_element;
	} soc_item_t;

	typedef struct packed {
		logic fire;
		logic restart;
		logic text;
		logic last;
		logic hit;
	} soc_evt_t;

endpackage

`default_nettype wire

>>> hdl/soc_match.sv
`default_nettype none

module soc_match #(
	parameter int MAX_PATTERN = soc_pkg::MAX_PATTERN_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire soc_pkg::soc_item_t item,
	input  wire logic              fire,
	output soc_pkg::soc_evt_t      evt
);
	import soc_pkg::*;

	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

	logic [31:0]            pat_q [MAX_PATTERN];
	logic [LEN_W-1:0]       len_q;
	logic                   closed_q;
	logic [MAX_PATTERN-1:0] prefix_q;
	logic [MAX_PATTERN-1:0] prefix_next;
	logic [MAX_PATTERN-1:0] eq;
	logic [LEN_W-1:0]       base_len;
	logic                   has_room;
	logic                   is_text;
	logic [IDX_W-1:0]       sel_idx;
	logic                   hit;

	assign is_text  = (item.req_type == REQ_TEXT);
	assign base_len = closed_q ? '0 : len_q;
	assign has_room = (base_len < LEN_MAX);
	assign sel_idx  = IDX_W'(len_q - LEN_W'(1));

	// bit j: text ending at this word matches pattern words 0..j
	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cmp
		assign eq[j] = (item.element_value == pat_q[j]);
		if (j == 0) begin : g_first
			assign prefix_next[j] = eq[j];
		end else begin : g_rest
			assign prefix_next[j] = prefix_q[j-1] & eq[j];
		end
	end

	assign hit = (len_q != '0) && prefix_next[sel_idx];

	always_comb begin
		evt.fire    = fire;
		evt.restart = !is_text && closed_q;
		evt.text    = is_text;
		evt.last    = item.last_element;
		evt.hit     = hit;
	end

	always_ff @(posedge clk) begin
		if (fire && !is_text && has_room) begin
			pat_q[base_len[IDX_W-1:0]] <= item.element_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			closed_q <= 1'b0;
			prefix_q <= '0;
		end else if (fire) begin
			if (is_text) begin
				closed_q <= 1'b1;
				prefix_q <= item.last_element ? '0 : prefix_next;
			end else begin
				closed_q <= item.last_element;
				prefix_q <= '0;
				len_q    <= has_room ? base_len + LEN_W'(1) : base_len;
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/soc_result.sv
`default_nettype none

module soc_result (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire soc_pkg::soc_evt_t evt,
	input  wire logic             out_ready,
	output logic                  out_valid,
	output logic [15:0]           match_count
);
	import soc_pkg::*;

	logic [15:0] count_q;
	logic [15:0] count_inc;
	logic        emit;
	logic        out_valid_q;
	logic [15:0] match_count_q;

	assign count_inc = (evt.hit && count_q != COUNT_MAX) ? count_q + 16'd1 : count_q;
	assign emit      = evt.fire && evt.text && evt.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (evt.fire) begin
				if (evt.text) begin
					count_q <= evt.last ? '0 : count_inc;
				end else if (evt.restart) begin
					count_q <= '0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			match_count_q <= count_inc;
		end
	end

	assign out_valid   = out_valid_q;
	assign match_count = match_count_q;

endmodule

`default_nettype wire

>>> hdl/subsequence_occurrence_counter_top.sv
// Counts overlapping occurrences of a loaded pattern of 32-bit words in a streamed text.
// Send pattern words (req_type 0, up to MAX_PATTERN kept, last_element closes the pattern),
// then text words (req_type 1); the text beat with last_element set returns one
// match_count beat, saturating at 65535. A pattern beat after a finished or partial text
// starts a new pattern. One beat is taken every clock cycle; out_valid rises once its last text
// beat has gone through the input register and the output register, and input stalls only while
// a finished count waits in the output register and out_ready is low.
`default_nettype none

module subsequence_occurrence_counter_top #(
	parameter int MAX_PATTERN = soc_pkg::MAX_PATTERN_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               req_type,
	input  wire logic signed [31:0] element_value,
	input  wire logic               last_element,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [15:0]             match_count
);
	import soc_pkg::*;

	soc_item_t item_s1;
	logic      valid_s1;
	logic      advance;
	logic      emits;
	soc_evt_t  evt;

	assign emits    = (item_s1.req_type == REQ_TEXT) && item_s1.last_element;
	assign advance  = valid_s1 && (!emits || !out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.req_type      <= req_type;
			item_s1.element_value <= element_value;
			item_s1.last_element  <= last_element;
		end
	end

	soc_match #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_match (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.fire   (advance),
		.evt    (evt)
	);

	soc_result u_result (
		.clk         (clk),
		.arst_n      (arst_n),
		.evt         (evt),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.match_count (match_count)
	);

endmodule

`default_nettype wire

>>> hdl/soc_checker.sv
`default_nettype none

module soc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        req_type,
	input wire logic        last_element,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] match_count
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(match_count))
		else $error("result beat changed while stalled");

	// input never stalls while the output register is empty
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// a fresh result follows an accepted final text beat
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && req_type && last_element, 2))
		else $error("result without final text beat");

endmodule

bind subsequence_occurrence_counter_top soc_checker u_soc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.req_type     (req_type),
	.last_element (last_element),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.match_count  (match_count)
);

`default_nettype wire

>>> sim/subsequence_occurrence_counter_top_tb.sv
`timescale 1ns / 100ps

module subsequence_occurrence_counter_top_tb;
	import soc_pkg::*;

	localparam int WIN_DEPTH = MAX_PATTERN_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 1060;

	class count_scoreboard;
		bit [31:0] pattern_words [WIN_DEPTH];
		int unsigned pattern_len;
		bit [31:0] window [WIN_DEPTH];
		int unsigned text_count;
		bit [15:0] hits;
		bit closed;
		bit [15:0] expected_counts [$];
		int errors;

		task report(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		function void clear_text();
			foreach (window[i]) window[i] = '0;
			text_count = 0;
			hits = '0;
		endfunction

		function bit window_hit();
			int unsigned base;
			if (pattern_len == 0 || text_count < pattern_len)
				return 1'b0;
			base = WIN_DEPTH - pattern_len;
			for (int unsigned k = 0; k < pattern_len; k++) begin
				if (pattern_words[k] != window[base + k])
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function void note_input(logic kind, logic [31:0] word, logic last);
			if (kind == REQ_PATTERN) begin
				if (closed) begin
					pattern_len = 0;
					closed = 1'b0;
					clear_text();
				end
				if (pattern_len < WIN_DEPTH) begin
					pattern_words[pattern_len] = word;
					pattern_len++;
				end
				if (last)
					closed = 1'b1;
			end else begin
				closed = 1'b1;
				for (int i = 0; i + 1 < WIN_DEPTH; i++)
					window[i] = window[i + 1];
				window[WIN_DEPTH - 1] = word;
				if (text_count < WIN_DEPTH)
					text_count++;
				if (window_hit() && hits != COUNT_MAX)
					hits++;
				if (last) begin
					expected_counts.push_back(hits);
					clear_text();
				end
			end
		endfunction

		task check_result(logic [15:0] got);
			bit [15:0] want;
			if (expected_counts.size() == 0) begin
				report($sformatf("match_count %0d with none expected", got));
			end else begin
				want = expected_counts.pop_front();
				if (got !== want)
					report($sformatf("match_count got %0d want %0d", got, want));
			end
		endtask

		function int pending();
			return expected_counts.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic req_type;
	logic signed [31:0] element_value;
	logic last_element;
	logic out_valid;
	logic out_ready;
	logic [15:0] match_count;

	count_scoreboard sb;
	bit quiet;
	int unsigned n_sent;

	subsequence_occurrence_counter_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.element_value(element_value),
		.last_element(last_element),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.match_count(match_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		sb = new;
		quiet = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_PATTERN;
		element_value = '0;
		last_element = 1'b0;
		out_ready = 1'b1;
	end

	always @(negedge clk)
		out_ready <= quiet || ($urandom_range(99) >= 8);

	// beats are seen with pre-edge values
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_input(req_type, element_value, last_element);
			if (out_valid && out_ready)
				sb.check_result(match_count);
		end
	end

	initial begin : watchdog
		int unsigned stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stalled = 0;
			else
				stalled++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	task automatic send_beat(input logic kind, input logic [31:0] word, input logic last);
		while (!quiet && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		element_value <= word;
		last_element <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() > 0)
			@(negedge clk);
	endtask

	task automatic run_sequence();
		bit [31:0] sym [4];
		bit [31:0] pat [$];
		bit [31:0] txt [$];
		int unsigned plen;
		int unsigned nsym;
		int unsigned ntext;
		int unsigned tlen;
		bit close_pat;
		bit [31:0] word;
		int i;
		int t;
		for (i = 0; i < 4; i++)
			sym[i] = $urandom;
		plen = ($urandom_range(19) == 0) ? $urandom_range(70, 60) : $urandom_range(4, 1);
		nsym = (plen > 8) ? 2 : $urandom_range(4, 2);
		close_pat = ($urandom_range(3) != 0);
		for (i = 0; i < plen; i++) begin
			word = sym[$urandom_range(nsym - 1)];
			if (i < WIN_DEPTH)
				pat.push_back(word);
			send_beat(REQ_PATTERN, word, close_pat && (i == plen - 1));
		end
		ntext = $urandom_range(3, 1);
		for (t = 0; t < ntext; t++) begin
			tlen = (plen > 8) ? $urandom_range(plen + 60, plen - 4) : $urandom_range(20, 1);
			txt.delete();
			while (txt.size() < tlen) begin
				if ($urandom_range(2) == 0) begin
					foreach (pat[k])
						txt.push_back(pat[k]);
				end else begin
					txt.push_back(sym[$urandom_range(nsym - 1)]);
				end
			end
			foreach (txt[k])
				send_beat(REQ_TEXT, txt[k], k == txt.size() - 1);
		end
	endtask

	task automatic run_noise();
		int unsigned n;
		n = $urandom_range(10, 1);
		repeat (n)
			send_beat(1'($urandom_range(1)), $urandom, 1'($urandom_range(1)));
	endtask

	initial begin : stimulus
		int unsigned rand_start;
		int unsigned seq_idx;
		n_sent = 0;
		repeat (10)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty pattern
		send_beat(REQ_TEXT, 32'h7FFF_FFFF, 1'b0);
		send_beat(REQ_TEXT, 32'h8000_0000, 1'b1);
		// two-word pattern, two hits
		send_beat(REQ_PATTERN, 32'h8000_0000, 1'b0);
		send_beat(REQ_PATTERN, 32'hFFFF_FFFF, 1'b1);
		send_beat(REQ_TEXT, 32'h8000_0000, 1'b0);
		send_beat(REQ_TEXT, 32'hFFFF_FFFF, 1'b0);
		send_beat(REQ_TEXT, 32'h8000_0000, 1'b0);
		send_beat(REQ_TEXT, 32'hFFFF_FFFF, 1'b1);
		// short text
		send_beat(REQ_TEXT, 32'h8000_0000, 1'b1);
		// text abandoned by a new pattern, overlapping hits
		send_beat(REQ_TEXT, 32'h8000_0000, 1'b0);
		send_beat(REQ_PATTERN, 32'h0000_0000, 1'b0);
		send_beat(REQ_PATTERN, 32'h0000_0000, 1'b1);
		send_beat(REQ_TEXT, 32'h0000_0000, 1'b0);
		send_beat(REQ_TEXT, 32'h0000_0000, 1'b0);
		send_beat(REQ_TEXT, 32'h0000_0000, 1'b1);
		// closed pattern replaced without any text
		send_beat(REQ_PATTERN, 32'h0000_0005, 1'b1);
		send_beat(REQ_PATTERN, 32'h0000_0007, 1'b1);
		send_beat(REQ_TEXT, 32'h0000_0007, 1'b0);
		send_beat(REQ_TEXT, 32'h0000_0005, 1'b0);
		send_beat(REQ_TEXT, 32'h0000_0007, 1'b1);
		// open pattern closed by a text beat
		send_beat(REQ_PATTERN, 32'h0000_0001, 1'b0);
		send_beat(REQ_TEXT, 32'h0000_0001, 1'b1);
		wait_drained();

		rand_start = n_sent;
		seq_idx = 0;
		while (n_sent - rand_start < RANDOM_ITEMS) begin
			quiet = (seq_idx >= 8 && seq_idx < 16);
			if ($urandom_range(99) < 80)
				run_sequence();
			else
				run_noise();
			if ($urandom_range(9) == 0)
				wait_drained();
			seq_idx++;
		end
		quiet = 1'b0;

		wait_drained();
		repeat (10)
			@(negedge clk);
		if (sb.pending() > 0)
			sb.report($sformatf("%0d match_count beats never arrived", sb.pending()));
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
